### rtl/nscv_pkg.sv
package nscv_pkg;

    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] MIN_LINE_LENGTH = 4'd14;
    localparam logic [POS_W-1:0] SEPARATOR_INDEX = 4'd6;
    localparam logic [1:0] SUM_CHARS = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;

    typedef enum logic [2:0] {
        REASON_OK       = 3'd0,
        REASON_SHORT    = 3'd1,
        REASON_NO_BANG  = 3'd2,
        REASON_NO_COMMA = 3'd3,
        REASON_NO_STAR  = 3'd4,
        REASON_NO_SUM   = 3'd5,
        REASON_MISMATCH = 3'd6
    } reason_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       end_of_line;
    } in_req_t;

    typedef struct packed {
        logic       line_valid;
        logic [2:0] fail_reason;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } out_req_t;

    // per-line summary passed from front to back
    typedef struct packed {
        logic       len_ok;
        logic       start_ok;
        logic       sep_ok;
        logic       star_seen;
        logic       two_after;
        logic [7:0] xor_sum;
        logic [7:0] first_char;
        logic [7:0] second_char;
    } line_sum_t;

    function automatic logic is_space_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // {digit ok, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
            d = c - CHAR_ZERO;
            return {1'b1, d[3:0]};
        end
        if ((c >= CHAR_LC_A) && (c <= CHAR_LC_F)) begin
            d = c - CHAR_LC_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        if ((c >= CHAR_UC_A) && (c <= CHAR_UC_F)) begin
            d = c - CHAR_UC_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] parse_sum(input logic [7:0] c1, input logic [7:0] c2);
        logic [4:0] h1;
        logic [4:0] h2;
        logic [7:0] v;
        h1 = hex_value(c1);
        h2 = hex_value(c2);
        v  = h2[4] ? {4'h0, h2[3:0]} : 8'h00;
        if (is_space_char(c1)) begin
            if ((c2 == CHAR_PLUS) || (c2 == CHAR_MINUS)) begin
                return 8'h00;
            end
            return v;
        end
        if ((c1 == CHAR_PLUS) || (c1 == CHAR_MINUS)) begin
            if (c1 == CHAR_MINUS) begin
                return 8'h00 - v;
            end
            return v;
        end
        if (!h1[4]) begin
            return 8'h00;
        end
        if (!h2[4]) begin
            return {4'h0, h1[3:0]};
        end
        return {h1[3:0], h2[3:0]};
    endfunction

endpackage

### rtl/nmea_sentence_checksum_validator_unit.sv
// m_valid rises once the line summary, written into the queue at the edge that takes the request
// carrying end_of_line, has been loaded into the result register; with m_ready high it is then taken.
// One byte request per cycle while s_ready is high; at most one result per cycle.
// The per-byte checks and XOR update in the front set the rate; a two-entry queue
// sits between the front and the registered result stage. With both full, s_ready drops.
// Reset (aresetn low, synchronous) clears line state, the queue and m_valid.
module nmea_sentence_checksum_validator_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nscv_pkg::in_req_t s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output nscv_pkg::out_req_t m_res
);
    import nscv_pkg::*;

    logic      push_valid;
    logic      push_ready;
    line_sum_t push_sum;
    logic      pop_valid;
    logic      pop_ready;
    line_sum_t pop_sum;

    nscv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum)
    );

    nscv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_sum    (pop_sum)
    );

    nscv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_sum   (pop_sum),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

endmodule

### rtl/nscv_front.sv
module nscv_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nscv_pkg::in_req_t   s_req,
    output logic                push_valid,
    input  logic                push_ready,
    output nscv_pkg::line_sum_t push_sum
);
    import nscv_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             start_reg, start_next;
    logic             sep_reg, sep_next;
    logic             star_reg, star_next;
    logic [1:0]       after_reg, after_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       c1_reg, c1_next;
    logic [7:0]       c2_reg, c2_next;
    logic             accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    always_comb begin
        start_next = start_reg;
        sep_next   = sep_reg;
        star_next  = star_reg;
        after_next = after_reg;
        xor_next   = xor_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        pos_next   = pos_reg;

        if (pos_reg == '0) begin
            start_next = (s_req.line_byte == CHAR_BANG);
        end
        if (pos_reg == SEPARATOR_INDEX) begin
            sep_next = (s_req.line_byte == CHAR_COMMA);
        end
        if (!star_reg) begin
            if (s_req.line_byte == CHAR_STAR) begin
                star_next = 1'b1;
            end else if (pos_reg != '0) begin
                xor_next = xor_reg ^ s_req.line_byte;
            end
        end else if (after_reg < SUM_CHARS) begin
            if (after_reg == 2'd0) begin
                c1_next = s_req.line_byte;
            end else begin
                c2_next = s_req.line_byte;
            end
            after_next = after_reg + 2'd1;
        end
        if (pos_reg < MIN_LINE_LENGTH) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb begin
        push_valid            = s_valid && s_req.end_of_line;
        push_sum.len_ok       = (pos_next >= MIN_LINE_LENGTH);
        push_sum.start_ok     = start_next;
        push_sum.sep_ok       = sep_next;
        push_sum.star_seen    = star_next;
        push_sum.two_after    = (after_next >= SUM_CHARS);
        push_sum.xor_sum      = xor_next;
        push_sum.first_char   = c1_next;
        push_sum.second_char  = c2_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_req.end_of_line)) begin
            pos_reg   <= '0;
            start_reg <= 1'b0;
            sep_reg   <= 1'b0;
            star_reg  <= 1'b0;
            after_reg <= 2'd0;
            xor_reg   <= 8'h00;
            c1_reg    <= 8'h00;
            c2_reg    <= 8'h00;
        end else if (accept) begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            sep_reg   <= sep_next;
            star_reg  <= star_next;
            after_reg <= after_next;
            xor_reg   <= xor_next;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
        end
    end

endmodule

### rtl/nscv_queue.sv
module nscv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  nscv_pkg::line_sum_t push_sum,
    output logic                pop_valid,
    input  logic                pop_ready,
    output nscv_pkg::line_sum_t pop_sum
);
    import nscv_pkg::*;

    line_sum_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_sum    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_sum;
        end
    end

endmodule

### rtl/nscv_back.sv
module nscv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  nscv_pkg::line_sum_t pop_sum,
    output logic                m_valid,
    input  logic                m_ready,
    output nscv_pkg::out_req_t  m_res
);
    import nscv_pkg::*;

    logic     m_valid_reg, m_valid_next;
    out_req_t m_res_reg, m_res_next;
    logic     load;
    logic [7:0] received;
    reason_t  reason;

    assign pop_ready = !m_valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;
    assign m_res     = m_res_reg;

    always_comb begin
        received = pop_sum.two_after ? parse_sum(pop_sum.first_char, pop_sum.second_char)
                                     : 8'h00;
        if (!pop_sum.len_ok) begin
            reason = REASON_SHORT;
        end else if (!pop_sum.start_ok) begin
            reason = REASON_NO_BANG;
        end else if (!pop_sum.sep_ok) begin
            reason = REASON_NO_COMMA;
        end else if (!pop_sum.star_seen) begin
            reason = REASON_NO_STAR;
        end else if (!pop_sum.two_after) begin
            reason = REASON_NO_SUM;
        end else if (pop_sum.xor_sum != received) begin
            reason = REASON_MISMATCH;
        end else begin
            reason = REASON_OK;
        end

        m_res_next.line_valid   = (reason == REASON_OK);
        m_res_next.fail_reason  = reason;
        m_res_next.computed_sum = pop_sum.xor_sum;
        m_res_next.received_sum = received;

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_res_reg <= m_res_next;
        end
    end

endmodule

### rtl/nscv_checker.sv
module nscv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input nscv_pkg::in_req_t  s_req,
    input logic               m_valid,
    input logic               m_ready,
    input nscv_pkg::out_req_t m_res
);
    import nscv_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("stalled result changed");

    a_valid_vs_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_res.line_valid == (m_res.fail_reason == REASON_OK)))
        else $error("line_valid disagrees with fail_reason");

    a_valid_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.line_valid |-> (m_res.computed_sum == m_res.received_sum))
        else $error("valid line with differing sums");

endmodule

bind nmea_sentence_checksum_validator_unit nscv_checker u_checker (.*);

### verif/tb_nmea_sentence_checksum_validator_unit.sv
module tb_nmea_sentence_checksum_validator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import nscv_pkg::*;

    typedef enum int {
        SUM_UPPER,
        SUM_LOWER,
        SUM_WRONG,
        SUM_SPACE,
        SUM_PLUS,
        SUM_MINUS,
        SUM_HEX_PREFIX,
        SUM_RANDOM
    } sum_style_t;

    class line_checker;
        out_req_t   pending[$];
        int         errors;
        logic [3:0] pos;
        logic       bang_ok;
        logic       comma_ok;
        logic       star_found;
        logic [1:0] n_after;
        logic [7:0] xor_acc;
        logic [7:0] sum_c1;
        logic [7:0] sum_c2;

        function void clear_line();
            pos        = '0;
            bang_ok    = 1'b0;
            comma_ok   = 1'b0;
            star_found = 1'b0;
            n_after    = '0;
            xor_acc    = '0;
            sum_c1     = '0;
            sum_c2     = '0;
        endfunction

        function bit hex_digit(input logic [7:0] c, output logic [3:0] n);
            n = '0;
            if (c >= "0" && c <= "9") begin
                n = 4'(c - "0");
                return 1'b1;
            end
            if (c >= "a" && c <= "f") begin
                n = 4'(c - "a" + 10);
                return 1'b1;
            end
            if (c >= "A" && c <= "F") begin
                n = 4'(c - "A" + 10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // strtol base 16 over two characters, modulo 256
        function logic [7:0] sum_text_value(input logic [7:0] c1, input logic [7:0] c2);
            logic [3:0] n1;
            logic [3:0] n2;
            logic       ok1;
            logic       ok2;
            logic [7:0] v;
            ok1 = hex_digit(c1, n1);
            ok2 = hex_digit(c2, n2);
            v   = ok2 ? {4'h0, n2} : 8'h00;
            if (c1 == CHAR_SPACE || (c1 >= CHAR_TAB && c1 <= CHAR_CR)) begin
                if (c2 == CHAR_PLUS || c2 == CHAR_MINUS) begin
                    return 8'h00;
                end
                return v;
            end
            if (c1 == CHAR_PLUS) begin
                return v;
            end
            if (c1 == CHAR_MINUS) begin
                return 8'h00 - v;
            end
            if (!ok1) begin
                return 8'h00;
            end
            if (!ok2) begin
                return {4'h0, n1};
            end
            return {n1, n2};
        endfunction

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void note_byte(input in_req_t r);
            out_req_t   res;
            reason_t    why;
            logic [7:0] rx;
            if (pos == 0) begin
                bang_ok = (r.line_byte == CHAR_BANG);
            end
            if (pos == SEPARATOR_INDEX) begin
                comma_ok = (r.line_byte == CHAR_COMMA);
            end
            if (!star_found) begin
                if (r.line_byte == CHAR_STAR) begin
                    star_found = 1'b1;
                end else if (pos != 0) begin
                    xor_acc = xor_acc ^ r.line_byte;
                end
            end else if (n_after < 2) begin
                if (n_after == 0) begin
                    sum_c1 = r.line_byte;
                end else begin
                    sum_c2 = r.line_byte;
                end
                n_after = n_after + 2'd1;
            end
            if (pos < MIN_LINE_LENGTH) begin
                pos = pos + 4'd1;
            end
            if (!r.end_of_line) begin
                return;
            end
            rx = (n_after >= 2) ? sum_text_value(sum_c1, sum_c2) : 8'h00;
            if (pos < MIN_LINE_LENGTH) begin
                why = REASON_SHORT;
            end else if (!bang_ok) begin
                why = REASON_NO_BANG;
            end else if (!comma_ok) begin
                why = REASON_NO_COMMA;
            end else if (!star_found) begin
                why = REASON_NO_STAR;
            end else if (n_after < 2) begin
                why = REASON_NO_SUM;
            end else if (xor_acc != rx) begin
                why = REASON_MISMATCH;
            end else begin
                why = REASON_OK;
            end
            res.line_valid   = (why == REASON_OK);
            res.fail_reason  = why;
            res.computed_sum = xor_acc;
            res.received_sum = rx;
            pending = {pending, res};
            clear_line();
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 20) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task check_result(input out_req_t got);
            out_req_t exp;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            exp = pending.pop_front();
            if (got.line_valid !== exp.line_valid) begin
                report_mismatch($sformatf("line_valid got %b exp %b",
                                          got.line_valid, exp.line_valid));
            end
            if (got.fail_reason !== exp.fail_reason) begin
                report_mismatch($sformatf("fail_reason got %0d exp %0d",
                                          got.fail_reason, exp.fail_reason));
            end
            if (got.computed_sum !== exp.computed_sum) begin
                report_mismatch($sformatf("computed_sum got %h exp %h",
                                          got.computed_sum, exp.computed_sum));
            end
            if (got.received_sum !== exp.received_sum) begin
                report_mismatch($sformatf("received_sum got %h exp %h",
                                          got.received_sum, exp.received_sum));
            end
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_req_t    s_req;
    logic       m_valid;
    logic       m_ready;
    out_req_t   m_res;

    line_checker board;
    logic [7:0]  line_buf[$];
    int          star_idx;
    int          results_seen;

    nmea_sentence_checksum_validator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("** nmea_sentence_checksum_validator_unit: FAILED **");
        $finish;
    end

    // result side; two long hold-offs fill the block and stall its input
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        results_seen = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results_seen == 4 || results_seen == 20) begin
                gap = 400;
            end else if ((results_seen / 10) % 3 == 1) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_res);
            results_seen++;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eol, input int gap);
        in_req_t req;
        req.line_byte   = b;
        req.end_of_line = eol;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(req);
    endtask

    task automatic send_line(input bit burst);
        int gap;
        for (int i = 0; i < line_buf.size(); i++) begin
            gap = burst ? 0 : $urandom_range(0, 6);
            send_byte(line_buf[i], i == line_buf.size() - 1, gap);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) begin
            return 8'("0" + n);
        end
        return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
    endfunction

    function automatic logic [7:0] ws_pick();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r);
    endfunction

    function automatic sum_style_t pick_style();
        int r;
        r = $urandom_range(0, 15);
        if (r <= 5) return SUM_UPPER;
        if (r <= 8) return SUM_LOWER;
        if (r == 9) return SUM_WRONG;
        if (r == 10) return SUM_SPACE;
        if (r == 11) return SUM_PLUS;
        if (r == 12) return SUM_MINUS;
        if (r == 13) return SUM_HEX_PREFIX;
        return SUM_RANDOM;
    endfunction

    // "!" + 5 letters + "," + body + "*" + two sum characters + tail
    task automatic build_sentence(input int body_len, input sum_style_t style,
                                  input int tail_len);
        logic [7:0] c;
        logic [7:0] x;
        logic [7:0] w;
        line_buf.delete();
        line_buf = {line_buf, CHAR_BANG};
        repeat (5) line_buf = {line_buf, 8'($urandom_range(65, 90))};
        line_buf = {line_buf, CHAR_COMMA};
        repeat (body_len) begin
            c = 8'($urandom_range(32, 126));
            if (c == CHAR_STAR) begin
                c = CHAR_ZERO;
            end
            line_buf = {line_buf, c};
        end
        x = '0;
        for (int i = 1; i < line_buf.size(); i++) begin
            x = x ^ line_buf[i];
        end
        star_idx = line_buf.size();
        line_buf = {line_buf, CHAR_STAR};
        case (style)
            SUM_UPPER, SUM_LOWER: begin
                line_buf = {line_buf, hex_char(x[7:4], style == SUM_LOWER)};
                line_buf = {line_buf, hex_char(x[3:0], style == SUM_LOWER)};
            end
            SUM_WRONG: begin
                w = x ^ 8'($urandom_range(1, 255));
                line_buf = {line_buf, hex_char(w[7:4], 1'b0)};
                line_buf = {line_buf, hex_char(w[3:0], 1'b0)};
            end
            SUM_SPACE: begin
                line_buf = {line_buf, ws_pick()};
                c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                                  hex_char(x[3:0], $urandom_range(0, 1));
                line_buf = {line_buf, c};
            end
            SUM_PLUS: begin
                line_buf = {line_buf, CHAR_PLUS};
                line_buf = {line_buf, hex_char(x[3:0], $urandom_range(0, 1))};
            end
            SUM_MINUS: begin
                line_buf = {line_buf, CHAR_MINUS};
                line_buf = {line_buf, hex_char(4'($urandom_range(0, 15)),
                                               $urandom_range(0, 1))};
            end
            SUM_HEX_PREFIX: begin
                line_buf = {line_buf, CHAR_ZERO};
                c = $urandom_range(0, 1) ? "x" : "X";
                line_buf = {line_buf, c};
            end
            default: begin
                line_buf = {line_buf, 8'($urandom_range(0, 255))};
                line_buf = {line_buf, 8'($urandom_range(0, 255))};
            end
        endcase
        repeat (tail_len) line_buf = {line_buf, 8'($urandom_range(0, 255))};
    endtask

    task automatic noise_line(input int len);
        line_buf.delete();
        repeat (len) line_buf = {line_buf, 8'($urandom_range(0, 255))};
        if ($urandom_range(0, 2) == 0) begin
            line_buf[0] = CHAR_BANG;
        end
    endtask

    initial begin : stimulus
        int rand_bytes;
        int rand_lines;
        int cut;
        int waited;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req   = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_sentence(6, SUM_UPPER, 0);
        send_line(1'b0);
        build_sentence(6, SUM_LOWER, 0);
        send_line(1'b1);
        build_sentence(5, SUM_WRONG, 0);
        send_line(1'b0);
        build_sentence(3, SUM_UPPER, 0);
        send_line(1'b0);
        line_buf = '{CHAR_BANG};
        send_line(1'b0);
        line_buf = '{8'hFF};
        send_line(1'b0);
        line_buf = '{8'h00};
        send_line(1'b0);
        build_sentence(6, SUM_UPPER, 0);
        line_buf[0] = "$";
        send_line(1'b0);
        build_sentence(6, SUM_UPPER, 0);
        line_buf[0] = CHAR_STAR;
        send_line(1'b0);
        build_sentence(6, SUM_UPPER, 0);
        line_buf[SEPARATOR_INDEX] = ";";
        send_line(1'b0);
        build_sentence(6, SUM_UPPER, 0);
        line_buf[star_idx] = "Z";
        send_line(1'b0);
        build_sentence(8, SUM_UPPER, 0);
        void'(line_buf.pop_back());
        send_line(1'b0);
        build_sentence(8, SUM_UPPER, 0);
        void'(line_buf.pop_back());
        void'(line_buf.pop_back());
        send_line(1'b1);
        build_sentence(6, SUM_SPACE, 0);
        send_line(1'b0);
        build_sentence(6, SUM_SPACE, 0);
        line_buf[star_idx + 2] = CHAR_MINUS;
        send_line(1'b0);
        build_sentence(6, SUM_PLUS, 0);
        send_line(1'b0);
        build_sentence(6, SUM_MINUS, 0);
        send_line(1'b0);
        build_sentence(6, SUM_HEX_PREFIX, 0);
        send_line(1'b0);
        build_sentence(6, SUM_UPPER, 0);
        line_buf[star_idx + 2] = "G";
        send_line(1'b0);
        build_sentence(6, SUM_UPPER, 4);
        line_buf[line_buf.size() - 2] = CHAR_STAR;
        send_line(1'b0);
        build_sentence(30, SUM_LOWER, 0);
        send_line(1'b1);
        noise_line(14);
        send_line(1'b0);

        rand_bytes = 0;
        rand_lines = 0;
        while (rand_bytes < 170 || rand_lines < 10) begin
            case ($urandom_range(0, 9))
                8, 9: begin
                    noise_line($urandom_range(1, 20));
                end
                7: begin
                    build_sentence($urandom_range(4, 12), pick_style(), 0);
                    if ($urandom_range(0, 1)) begin
                        line_buf[$urandom_range(0, line_buf.size() - 1)] =
                            8'($urandom_range(0, 255));
                    end else begin
                        cut = $urandom_range(1, line_buf.size());
                        while (line_buf.size() > cut) void'(line_buf.pop_back());
                    end
                end
                default: begin
                    build_sentence($urandom_range(4, 12), pick_style(),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
                end
            endcase
            rand_bytes += line_buf.size();
            rand_lines++;
            send_line($urandom_range(0, 3) == 0);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (board.pending.size() != 0) begin
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.pending.size()));
        end
        if (board.errors == 0) begin
            $display("** nmea_sentence_checksum_validator_unit: PASSED **");
        end else begin
            $display("** nmea_sentence_checksum_validator_unit: FAILED **");
        end
        $finish;
    end

endmodule
